// File: rtl/sefp_pkg.sv
// Shared types and constants for the start/length/end framed byte parser.
package sefp_pkg;

    // Parser phases; unused encodings behave as idle.
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_LEN  = 3'd1,
        PH_CMD  = 3'd2,
        PH_D1   = 3'd3,
        PH_D2   = 3'd4,
        PH_END  = 3'd5,
        PH_PAY  = 3'd6
    } phase_t;

    // Kind of result produced for each received byte.
    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PAYLOAD = 2'd1,
        EV_FRAME   = 2'd2,
        EV_ERROR   = 2'd3
    } evt_kind_t;

    // One result beat as it travels from the parser to the output stage.
    typedef struct packed {
        logic [7:0] payload_index;
        logic [7:0] payload_value;
        logic [7:0] second_data;
        logic [7:0] first_data;
        logic [7:0] command_code;
        logic [7:0] frame_length;
        evt_kind_t  event_res;
    } result_t;

    // Register indexes on the configuration port (taken from paddr[2]).
    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_END_MARKER   = 1'b1;

    // Marker values after reset.
    localparam logic [7:0] START_MARKER_RESET = 8'h02;
    localparam logic [7:0] END_MARKER_RESET   = 8'h03;

    // Command, data1 and data2 counted in the length field, plus one because the
    // payload index counts from zero; the payload ends once index plus this reaches the length.
    localparam logic [8:0] HEADER_BYTES = 9'd4;

endpackage

// File: rtl/stx_etx_frame_parser_unit.sv
// Top level of the framed serial byte parser with its configuration registers.
// Takes one received byte per beat on the s_ channel and gives exactly one result beat per
// byte on the m_ channel, in order. Bytes outside a frame produce no-event results until the
// start marker; a frame is start marker, length, command, data1 and data2 as the length
// allows, length minus three payload bytes (each reported with its index), then the end
// marker, which yields either a frame-complete result or an end-marker error. The block
// sustains one byte per clock while the queue has room: the parser phase advances on each
// accepted byte, and a result passes through the queue and then the output register. A
// QUEUE_DEPTH-entry queue between the parser and the output register lets the input keep
// flowing while the result side stalls, until the queue fills. The start and end markers are
// written over the APB port at byte addresses 0 and 4 (reset values 0x02 and 0x03) and should
// be changed only while no frame is in flight.
module stx_etx_frame_parser_unit
    import sefp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input byte stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] frame_length, [15:8] command_code, [23:16] first_data,
    // [31:24] second_data, [39:32] payload_value, [47:40] payload_index
    output logic [47:0] m_tdata,
    output logic [1:0]  m_tuser,   // [1:0] event_res
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] start_marker_reg;
    logic [7:0] end_marker_reg;
    logic       cfg_write;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_not_empty;
    result_t    q_item;
    result_t    q_head;

    // Register writes land on the access cycle of the APB transfer.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg <= START_MARKER_RESET;
            end_marker_reg   <= END_MARKER_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_START_MARKER: start_marker_reg <= pwdata[7:0];
                REG_END_MARKER:   end_marker_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        unique case (paddr[2])
            REG_START_MARKER: prdata = {24'd0, start_marker_reg};
            REG_END_MARKER:   prdata = {24'd0, end_marker_reg};
            default:          prdata = '0;
        endcase
    end

    sefp_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .start_marker (start_marker_reg),
        .end_marker   (end_marker_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (q_item)
    );

    sefp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (q_head)
    );

    sefp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// File: rtl/sefp_front.sv
// Parser front end: takes one byte per beat, steps the frame phase and builds its result.
module sefp_front
    import sefp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic [7:0] start_marker,
    input  logic [7:0] end_marker,
    input  logic       q_full,
    output logic       q_push,
    output result_t    q_item
);

    phase_t     phase_reg, phase_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] d1_reg, d1_next;
    logic [7:0] d2_reg, d2_next;
    logic [7:0] cnt_reg, cnt_next;
    logic       take;
    logic       last_payload;

    assign s_tready = !q_full;
    assign take     = s_tvalid && !q_full;
    assign q_push   = take;

    // The payload ends once count plus the header bytes reaches the length.
    assign last_payload = ({1'b0, cnt_reg} + HEADER_BYTES) >= {1'b0, len_reg};

    // Next phase, captured fields and the result for the current byte.
    always_comb begin
        phase_next = phase_reg;
        len_next   = len_reg;
        cmd_next   = cmd_reg;
        d1_next    = d1_reg;
        d2_next    = d2_reg;
        cnt_next   = cnt_reg;
        q_item     = '0;
        q_item.event_res = EV_NONE;
        unique case (phase_reg)
            PH_LEN: begin
                len_next   = s_tdata;
                cnt_next   = '0;
                phase_next = PH_CMD;
            end
            PH_CMD: begin
                cmd_next   = s_tdata;
                phase_next = (len_reg <= 8'd1) ? PH_END : PH_D1;
            end
            PH_D1: begin
                d1_next    = s_tdata;
                phase_next = (len_reg <= 8'd2) ? PH_END : PH_D2;
            end
            PH_D2: begin
                d2_next    = s_tdata;
                phase_next = (len_reg <= 8'd3) ? PH_END : PH_PAY;
            end
            PH_PAY: begin
                q_item.event_res     = EV_PAYLOAD;
                q_item.payload_value = s_tdata;
                q_item.payload_index = cnt_reg;
                cnt_next             = cnt_reg + 8'd1;
                if (last_payload) begin
                    phase_next = PH_END;
                end
            end
            PH_END: begin
                if (s_tdata == end_marker) begin
                    q_item.event_res    = EV_FRAME;
                    q_item.frame_length = len_reg;
                    q_item.command_code = cmd_reg;
                    q_item.first_data   = (len_reg >= 8'd2) ? d1_reg : 8'd0;
                    q_item.second_data  = (len_reg >= 8'd3) ? d2_reg : 8'd0;
                    len_next = '0;
                    cmd_next = '0;
                    d1_next  = '0;
                    d2_next  = '0;
                end else begin
                    q_item.event_res = EV_ERROR;
                end
                phase_next = PH_IDLE;
            end
            default: begin
                phase_next = (s_tdata == start_marker) ? PH_LEN : PH_IDLE;
            end
        endcase
    end

    // State registers advance only on an accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            len_reg   <= '0;
            cmd_reg   <= '0;
            d1_reg    <= '0;
            d2_reg    <= '0;
            cnt_reg   <= '0;
        end else if (take) begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            cmd_reg   <= cmd_next;
            d1_reg    <= d1_next;
            d2_reg    <= d2_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: rtl/sefp_queue.sv
// Short result queue that decouples the parser from the output stage.
module sefp_queue
    import sefp_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_item,
    output logic    full,
    input  logic    pop,
    output logic    not_empty,
    output result_t head_item
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    result_t       slots [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_item = slots[rd_ptr_reg];

    // Pointer wrap and occupancy.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/sefp_back.sv
// Output stage: moves queued results into the registered result channel.
module sefp_back
    import sefp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_not_empty,
    input  result_t     q_head,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    output logic [1:0]  m_tuser
);

    logic    valid_reg;
    result_t item_reg;
    logic    load;

    // Refill the output register when it is empty or its beat is being taken.
    assign load  = q_not_empty && (!valid_reg || m_tready);
    assign q_pop = load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= q_head;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = item_reg.event_res;
    assign m_tdata  = {item_reg.payload_index, item_reg.payload_value,
                       item_reg.second_data, item_reg.first_data,
                       item_reg.command_code, item_reg.frame_length};

endmodule
